[sv/rclfr_pkg.sv]
// rclfr_pkg: shared types, constants and functions of the rc link frame receiver
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package rclfr_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int CHANNELS        = 16;
  localparam int CH_BITS         = 11;
  localparam int RC_PAYLOAD      = 22;
  localparam int LINK_PAYLOAD    = 10;
  localparam int RC_LEN          = RC_PAYLOAD + 2;
  localparam int LINK_LEN        = LINK_PAYLOAD + 2;
  localparam int PAYLOAD_W       = RC_PAYLOAD * 8;
  localparam int JOB_DEPTH       = 2;
  localparam int POWER_ENTRIES   = 9;
  localparam logic [7:0]  CRC_POLY        = 8'hD5;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd1100;
  localparam logic [7:0]  RC_TYPE_RESET   = 8'd22;
  localparam logic [7:0]  LINK_TYPE_RESET = 8'd20;
  localparam logic [11:0] PULSE_OFFSET    = 12'd881;
  localparam logic [10:0] PULSE_DIV       = 11'd1639;
  localparam logic [11:0] PULSE_RECIP     = 12'd2559;  // floor(2^22 / 1639)

  // opcodes of an input item
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_LINK    = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_RC_TYPE   = 2'd1;
  localparam logic [1:0] REG_LINK_TYPE = 2'd2;

  // one decoded frame handed from front to back
  typedef struct packed {
    logic                 kind;
    logic [PAYLOAD_W-1:0] payload;
  } job_t;

  // crc-8, polynomial 0xd5, msb first
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

  // transmit power index to milliwatts
  function automatic logic [10:0] power_mw(input logic [7:0] idx);
    logic [10:0] mw;
    case (idx)
      8'd0:    mw = 11'd0;
      8'd1:    mw = 11'd10;
      8'd2:    mw = 11'd25;
      8'd3:    mw = 11'd100;
      8'd4:    mw = 11'd500;
      8'd5:    mw = 11'd1000;
      8'd6:    mw = 11'd2000;
      8'd7:    mw = 11'd250;
      8'd8:    mw = 11'd50;
      default: mw = 11'd0;
    endcase
    return mw;
  endfunction

endpackage
`default_nettype wire

[sv/rc_link_frame_receiver.sv]
// rc_link_frame_receiver: top level, front, job queue and back
// depends on rclfr_pkg, rclfr_front, rclfr_queue, rclfr_back
`timescale 1ns / 1ps
`default_nettype none
// Takes one item per clock unless full: a received byte or a microsecond tick.
// Framing, timeout and crc run in the front at one byte per cycle; a good channels or
// link statistics frame becomes a job in a two entry queue. The back unpacks a job
// through a three stage pipeline (channel select, reciprocal multiply, correction)
// and gives one result per cycle while pop keeps up: sixteen for a channels frame,
// one for a link frame. full rises only while both queue entries hold jobs not yet
// drained, so bytes keep flowing while results wait on pop. Configuration must be
// written only while idle; the block does not enforce it.
module rc_link_frame_receiver import rclfr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic         opcode,
  input  wire logic [7:0]   data_byte,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         pop,
  output logic              empty,
  output logic              kind,
  output logic [3:0]        channel_index,
  output logic [10:0]       channel_raw,
  output logic [11:0]       channel_pulse_us,
  output logic signed [8:0] uplink_rssi,
  output logic [7:0]        uplink_quality,
  output logic signed [7:0] uplink_snr,
  output logic [7:0]        rf_mode,
  output logic [10:0]       tx_power_mw,
  output logic              active_antenna,
  output logic              last
);

  logic [15:0] frame_timeout_us;
  logic [7:0]  rc_channels_type, link_stats_type;
  job_t        fjob, qjob;
  logic        fpush, qempty, qpop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_timeout_us <= TIMEOUT_RESET;
      rc_channels_type <= RC_TYPE_RESET;
      link_stats_type  <= LINK_TYPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:   frame_timeout_us <= cfg_data;
        REG_RC_TYPE:   rc_channels_type <= cfg_data[7:0];
        REG_LINK_TYPE: link_stats_type  <= cfg_data[7:0];
        default:       ;
      endcase
    end
  end

  rclfr_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk, .rst,
    .accept(push && !full),
    .opcode, .data_byte,
    .frame_timeout_us, .rc_channels_type, .link_stats_type,
    .job(fjob), .job_push(fpush)
  );

  rclfr_queue u_queue (
    .clk, .rst,
    .push(fpush), .wdata(fjob),
    .pop(qpop), .rdata(qjob),
    .full, .empty(qempty)
  );

  rclfr_back u_back (
    .clk, .rst,
    .job(qjob), .job_valid(!qempty), .job_pop(qpop),
    .pop, .empty,
    .kind, .channel_index, .channel_raw, .channel_pulse_us,
    .uplink_rssi, .uplink_quality, .uplink_snr, .rf_mode,
    .tx_power_mw, .active_antenna, .last
  );

endmodule
`default_nettype wire

[sv/rclfr_front.sv]
// rclfr_front: framing, timeout, crc check and frame classification
// depends on rclfr_pkg; feeds jobs to rclfr_queue
`timescale 1ns / 1ps
`default_nettype none
module rclfr_front import rclfr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic        opcode,
  input  wire logic [7:0]  data_byte,
  input  wire logic [15:0] frame_timeout_us,
  input  wire logic [7:0]  rc_channels_type,
  input  wire logic [7:0]  link_stats_type,
  output job_t             job,
  output logic             job_push
);

  localparam int PW = $clog2(FRAME_BYTES);
  localparam logic [7:0] MAX_LEN = 8'(FRAME_BYTES - 2);

  logic [PW-1:0] pos, pos_next;
  logic [15:0]   since;
  logic [7:0]    crc;
  logic [7:0]    len;
  logic [7:0]    ftype;
  logic [7:0]    sr [RC_PAYLOAD];  // sr[0] newest payload byte
  logic          is_byte;
  logic [PW-1:0] p0;
  logic [8:0]    full_cnt;
  logic          final_byte;
  logic          good_rc, good_link, crc_ok;

  assign is_byte    = accept && (opcode == OP_BYTE);
  assign p0         = (since > frame_timeout_us) ? '0 : pos;
  assign full_cnt   = {1'b0, len} + 9'd2;
  assign final_byte = ({{(9-PW){1'b0}}, p0} + 9'd1) == full_cnt;
  assign crc_ok     = crc == data_byte;
  assign good_rc    = ftype == rc_channels_type && len == 8'(RC_LEN);
  assign good_link  = ftype == link_stats_type && len == 8'(LINK_LEN);

  // next byte position
  always_comb begin
    pos_next = p0 + PW'(1);
    if (p0 == PW'(1) && (data_byte < 8'd2 || data_byte > MAX_LEN)) begin
      pos_next = '0;
    end else if (p0 >= PW'(3) && final_byte) begin
      pos_next = '0;
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      since <= '0;
      crc   <= '0;
    end else if (accept) begin
      if (opcode == OP_TICK) begin
        if (since != 16'hFFFF) since <= since + 16'd1;
      end else begin
        if (p0 == '0) since <= '0;
        pos <= pos_next;
        if (p0 == PW'(2)) begin
          crc <= crc_update(8'd0, data_byte);
        end else if (p0 >= PW'(3) && !final_byte) begin
          crc <= crc_update(crc, data_byte);
        end
      end
    end
  end

  // header and payload bytes
  always_ff @(posedge clk) begin
    if (is_byte) begin
      if (p0 == PW'(1)) len <= data_byte;
      if (p0 == PW'(2)) ftype <= data_byte;
      if (p0 >= PW'(3) && !final_byte) begin
        sr[0] <= data_byte;
        for (int i = 1; i < RC_PAYLOAD; i++) sr[i] <= sr[i-1];
      end
    end
  end

  // job on a good frame of a known type
  always_comb begin
    job      = '0;
    job_push = 1'b0;
    if (is_byte && p0 >= PW'(3) && final_byte && crc_ok) begin
      if (good_rc) begin
        job_push = 1'b1;
        job.kind = KIND_CHANNEL;
        for (int i = 0; i < RC_PAYLOAD; i++) job.payload[i*8 +: 8] = sr[RC_PAYLOAD-1-i];
      end else if (good_link) begin
        job_push = 1'b1;
        job.kind = KIND_LINK;
        for (int i = 0; i < 7; i++) job.payload[i*8 +: 8] = sr[LINK_PAYLOAD-1-i];
      end
    end
  end

endmodule
`default_nettype wire

[sv/rclfr_queue.sv]
// rclfr_queue: short job queue between front and back
// depends on rclfr_pkg
`timescale 1ns / 1ps
`default_nettype none
module rclfr_queue import rclfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      wdata,
  input  wire logic pop,
  output job_t      rdata,
  output logic      full,
  output logic      empty
);

  localparam int AW = $clog2(JOB_DEPTH);

  job_t          mem [JOB_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign full  = count == (AW+1)'(JOB_DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(JOB_DEPTH-1)) ? '0 : wp + AW'(1);
      if (pop)  rp <= (rp == AW'(JOB_DEPTH-1)) ? '0 : rp + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

endmodule
`default_nettype wire

[sv/rclfr_back.sv]
// rclfr_back: unpacks jobs into results through a three stage pipeline
// depends on rclfr_pkg; reads jobs from rclfr_queue
`timescale 1ns / 1ps
`default_nettype none
module rclfr_back import rclfr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  job_t              job,
  input  wire logic         job_valid,
  output logic              job_pop,
  input  wire logic         pop,
  output logic              empty,
  output logic              kind,
  output logic [3:0]        channel_index,
  output logic [10:0]       channel_raw,
  output logic [11:0]       channel_pulse_us,
  output logic signed [8:0] uplink_rssi,
  output logic [7:0]        uplink_quality,
  output logic signed [7:0] uplink_snr,
  output logic [7:0]        rf_mode,
  output logic [10:0]       tx_power_mw,
  output logic              active_antenna,
  output logic              last
);

  typedef struct packed {
    logic        kind;
    logic [3:0]  idx;
    logic [10:0] raw;
    logic [8:0]  rssi;
    logic [7:0]  lq;
    logic [7:0]  snr;
    logic [7:0]  mode;
    logic [10:0] tx;
    logic        ant;
    logic        last;
  } res_t;

  logic        stall, issue;
  logic [3:0]  k;
  logic        v1, v2, vo;
  res_t        r0, r1, r2;
  logic [10:0] q2;
  logic [22:0] prod1;
  logic [21:0] rem;
  logic [10:0] q_fix;
  logic [7:0]  b_rssi1, b_rssi2, b_ant;

  assign stall   = vo && !pop;
  assign issue   = !stall && job_valid;
  assign job_pop = issue && (job.kind == KIND_LINK || k == 4'(CHANNELS-1));
  assign empty   = !vo;

  assign b_rssi1 = job.payload[7:0];
  assign b_rssi2 = job.payload[15:8];
  assign b_ant   = job.payload[39:32];

  // decode one result of the head job
  always_comb begin
    r0 = '0;
    if (job.kind == KIND_CHANNEL) begin
      r0.kind = KIND_CHANNEL;
      r0.idx  = k;
      r0.raw  = 11'(job.payload >> (k * CH_BITS));
      r0.last = k == 4'(CHANNELS-1);
    end else begin
      r0.kind = KIND_LINK;
      r0.ant  = b_ant != 8'd0;
      r0.rssi = 9'd0 - {1'b0, (b_ant != 8'd0) ? b_rssi2 : b_rssi1};
      r0.lq   = job.payload[23:16];
      r0.snr  = job.payload[31:24];
      r0.mode = job.payload[47:40];
      r0.tx   = power_mw(job.payload[55:48]);
      r0.last = 1'b1;
    end
  end

  // channel counter within a job
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (issue && job.kind == KIND_CHANNEL) begin
      k <= (k == 4'(CHANNELS-1)) ? '0 : k + 4'd1;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else if (!stall) begin
      v1 <= issue;
      v2 <= v1;
      vo <= v2;
    end
  end

  // quotient estimate, raw*1024/1639 is this or one more
  assign prod1 = r1.raw * PULSE_RECIP;
  assign rem   = {r2.raw, 10'd0} - 22'(q2 * PULSE_DIV);
  assign q_fix = (rem >= {11'd0, PULSE_DIV}) ? q2 + 11'd1 : q2;

  // pipeline payload
  always_ff @(posedge clk) begin
    if (!stall) begin
      r1 <= r0;
      r2 <= r1;
      q2 <= prod1[22:12];
      kind             <= r2.kind;
      channel_index    <= r2.idx;
      channel_raw      <= r2.raw;
      channel_pulse_us <= (r2.kind == KIND_CHANNEL) ? {1'b0, q_fix} + PULSE_OFFSET : 12'd0;
      uplink_rssi      <= r2.rssi;
      uplink_quality   <= r2.lq;
      uplink_snr       <= r2.snr;
      rf_mode          <= r2.mode;
      tx_power_mw      <= r2.tx;
      active_antenna   <= r2.ant;
      last             <= r2.last;
    end
  end

endmodule
`default_nettype wire

[sv/rclfr_checker.sv]
// rclfr_checker: port level checks of the rc link frame receiver
// depends on rclfr_pkg; bound to rc_link_frame_receiver
`timescale 1ns / 1ps
`default_nettype none
module rclfr_checker import rclfr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic        kind,
  input wire logic [3:0]  channel_index,
  input wire logic [11:0] channel_pulse_us,
  input wire logic        last
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // a link result is a run of one
  a_link_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_LINK) |-> last)
    else $error("link result without last");

  // last marks the final channel only
  a_chan_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_CHANNEL) |-> (last == (channel_index == 4'(CHANNELS-1))))
    else $error("last on wrong channel");

  // pulse stays in its range
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_CHANNEL) |-> (channel_pulse_us >= 12'd881 &&
      channel_pulse_us <= 12'd2160))
    else $error("pulse out of range");

  // an untaken result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result dropped");

endmodule

bind rc_link_frame_receiver rclfr_checker u_rclfr_checker (
  .clk, .rst, .pop, .empty, .kind, .channel_index, .channel_pulse_us, .last
);
`default_nettype wire
